// File: src/tlik_pkg.sv
// Shared types, constants and arithmetic helpers for the two-link IK block.
`default_nettype none
package tlik_pkg;

  localparam int ANGLE_FRAC_BITS = 16;
  localparam int CORDIC_STEPS    = 18;
  localparam int ATAN_LEN        = 28;
  localparam int CORDIC_N        = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
  localparam int ANGLE_SHIFT     = 30 - ANGLE_FRAC_BITS;

  localparam int LEN_W = 20;  // link lengths
  localparam int POS_W = 22;  // foot coordinates
  localparam int ANG_W = 19;  // angles at the ports
  localparam int RAW_W = 22;  // rounded angles before wrapping
  localparam int AT_W  = 56;  // CORDIC x/y word
  localparam int Z_W   = 36;  // CORDIC angle accumulator, Q30
  localparam int CNT_W = 5;
  localparam int CFG_W = 20;
  localparam int IDX_W = 3;
  localparam int COST_W = 23;

  localparam logic signed [Z_W-1:0] PI_Q30 = 36'sd3373259426;
  localparam logic signed [Z_W-1:0] ROUND_HALF = Z_W'(1) <<< (ANGLE_SHIFT - 1);
  localparam logic signed [RAW_W-1:0] PI_ANG =
    RAW_W'((PI_Q30 + ROUND_HALF) >>> ANGLE_SHIFT);
  localparam logic signed [RAW_W-1:0] TWO_PI_ANG = PI_ANG <<< 1;

  localparam logic signed [Z_W-1:0] ATAN_TAB [0:ATAN_LEN-1] = '{
    36'sd843314857, 36'sd497837829, 36'sd263043837, 36'sd133525159, 36'sd67021687,
    36'sd33543516, 36'sd16775851, 36'sd8388437, 36'sd4194283, 36'sd2097149,
    36'sd1048576, 36'sd524288, 36'sd262144, 36'sd131072, 36'sd65536, 36'sd32768,
    36'sd16384, 36'sd8192, 36'sd4096, 36'sd2048, 36'sd1024, 36'sd512, 36'sd256,
    36'sd128, 36'sd64, 36'sd32, 36'sd16, 36'sd8
  };

  typedef enum logic [IDX_W-1:0] {
    REG_UPPER_LEN = 3'd0,
    REG_LOWER_LEN = 3'd1,
    REG_HIP_MIN   = 3'd2,
    REG_HIP_MAX   = 3'd3,
    REG_KNEE_MIN  = 3'd4,
    REG_KNEE_MAX  = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_LINK  = 2'd1,
    ST_UNREACH  = 2'd2,
    ST_NO_SOL   = 2'd3
  } ik_status_t;

  typedef enum logic [1:0] {
    JOB_PHI,
    JOB_KNEE,
    JOB_PSI
  } at_job_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LATCH, OP_DSQ1, OP_DSQ2, OP_LSUM, OP_LDIF, OP_L1SQ, OP_L2SQ,
    OP_DEN, OP_DIV, OP_CSET, OP_CSQ, OP_SQRT, OP_AT_LOAD, OP_AT_NORM, OP_AT_FIX,
    OP_AT_ROT, OP_AT_STORE, OP_PSI_Y, OP_PSI_X, OP_WRAP, OP_COST, OP_FINISH
  } dp_op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_DSQ1, S_DSQ2, S_LSUM, S_LDIF, S_REACH, S_L1SQ, S_L2SQ,
    S_DEN, S_DIV, S_CSET, S_CSQ, S_SQRT, S_AT_LOAD, S_AT_NORM, S_AT_FIX,
    S_AT_ROT, S_AT_STORE, S_PSI_Y, S_PSI_X, S_WRAP, S_COST, S_FIN
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t     op;
    at_job_t    job;
    logic       cand;
    ik_status_t code;
  } dp_cmd_t;

  typedef struct packed {
    logic link_zero;
    logic unreach;
    logic div_last;
    logic sqrt_last;
    logic at_zero;
    logic at_normed;
    logic rot_last;
    logic both;
  } dp_stat_t;

  // Rounds a Q30 angle to the output scale, halves away from zero.
  function automatic logic signed [RAW_W-1:0] round_ang(input logic signed [Z_W-1:0] v);
    logic signed [Z_W-1:0] t;
    if (v >= 0) begin
      t = (v + ROUND_HALF) >>> ANGLE_SHIFT;
    end else begin
      t = -((-v + ROUND_HALF) >>> ANGLE_SHIFT);
    end
    return t[RAW_W-1:0];
  endfunction

  // Wrap into [-pi, pi]; input magnitude stays below two turns.
  function automatic logic signed [RAW_W-1:0] wrap_ang(input logic signed [RAW_W-1:0] a);
    logic signed [RAW_W-1:0] r;
    r = a;
    if (r >= TWO_PI_ANG) begin
      r = r - TWO_PI_ANG;
    end else if (r <= -TWO_PI_ANG) begin
      r = r + TWO_PI_ANG;
    end
    if (r > PI_ANG) begin
      r = r - TWO_PI_ANG;
    end else if (r < -PI_ANG) begin
      r = r + TWO_PI_ANG;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: src/tlik_ctrl.sv
// Sequencer for the IK datapath and output handshake.
`default_nettype none
module tlik_ctrl
  import tlik_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  ctrl_state_t state, state_next;
  at_job_t     job, job_next;
  logic        cand, cand_next;
  ik_status_t  code, code_next;
  logic        out_valid_next;
  logic        out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      job       <= JOB_PHI;
      cand      <= 1'b0;
      code      <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      job       <= job_next;
      cand      <= cand_next;
      code      <= code_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    job_next       = job;
    cand_next      = cand;
    code_next      = code;
    out_valid_next = out_valid && out_stall;
    cmd.op         = OP_NONE;
    cmd.job        = job;
    cmd.cand       = cand;
    cmd.code       = code;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LATCH;
          code_next  = ST_OK;
          cand_next  = 1'b0;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.link_zero) begin
          code_next  = ST_NO_LINK;
          state_next = S_FIN;
        end else begin
          state_next = S_DSQ1;
        end
      end
      S_DSQ1: begin cmd.op = OP_DSQ1; state_next = S_DSQ2; end
      S_DSQ2: begin cmd.op = OP_DSQ2; state_next = S_LSUM; end
      S_LSUM: begin cmd.op = OP_LSUM; state_next = S_LDIF; end
      S_LDIF: begin cmd.op = OP_LDIF; state_next = S_REACH; end
      S_REACH: begin
        if (stat.unreach) begin
          code_next  = ST_UNREACH;
          state_next = S_FIN;
        end else begin
          state_next = S_L1SQ;
        end
      end
      S_L1SQ: begin cmd.op = OP_L1SQ; state_next = S_L2SQ; end
      S_L2SQ: begin cmd.op = OP_L2SQ; state_next = S_DEN; end
      S_DEN:  begin cmd.op = OP_DEN;  state_next = S_DIV; end
      S_DIV: begin
        cmd.op = OP_DIV;
        if (stat.div_last) state_next = S_CSET;
      end
      S_CSET: begin cmd.op = OP_CSET; state_next = S_CSQ; end
      S_CSQ:  begin cmd.op = OP_CSQ;  state_next = S_SQRT; end
      S_SQRT: begin
        cmd.op = OP_SQRT;
        if (stat.sqrt_last) begin
          job_next   = JOB_PHI;
          state_next = S_AT_LOAD;
        end
      end
      S_AT_LOAD: begin cmd.op = OP_AT_LOAD; state_next = S_AT_NORM; end
      S_AT_NORM: begin
        cmd.op = OP_AT_NORM;
        if (stat.at_zero) begin
          state_next = S_AT_STORE;
        end else if (stat.at_normed) begin
          state_next = S_AT_FIX;
        end
      end
      S_AT_FIX: begin cmd.op = OP_AT_FIX; state_next = S_AT_ROT; end
      S_AT_ROT: begin
        cmd.op = OP_AT_ROT;
        if (stat.rot_last) state_next = S_AT_STORE;
      end
      S_AT_STORE: begin
        cmd.op = OP_AT_STORE;
        case (job)
          JOB_PHI: begin
            job_next   = JOB_KNEE;
            state_next = S_AT_LOAD;
          end
          JOB_KNEE: state_next = S_PSI_Y;
          default:  state_next = S_WRAP;
        endcase
      end
      S_PSI_Y: begin cmd.op = OP_PSI_Y; state_next = S_PSI_X; end
      S_PSI_X: begin
        cmd.op     = OP_PSI_X;
        job_next   = JOB_PSI;
        state_next = S_AT_LOAD;
      end
      S_WRAP: begin cmd.op = OP_WRAP; state_next = S_COST; end
      S_COST: begin
        cmd.op = OP_COST;
        if (stat.both && !cand) begin
          cand_next  = 1'b1;
          job_next   = JOB_KNEE;
          state_next = S_AT_LOAD;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        // result waits here only while the output register is still full
        if (out_free) begin
          cmd.op         = OP_FINISH;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: src/tlik_datapath.sv
// IK datapath: config registers, multiplier, divider, square root, CORDIC, scoring.
`default_nettype none
module tlik_datapath
  import tlik_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_write,
  input  wire logic [IDX_W-1:0]        cfg_index,
  input  wire logic [CFG_W-1:0]        cfg_data,
  input  wire logic signed [POS_W-1:0] foot_x,
  input  wire logic signed [POS_W-1:0] foot_z,
  input  wire logic [1:0]              branch_mode,
  input  wire dp_cmd_t                 cmd,
  output dp_stat_t                     stat,
  output logic signed [ANG_W-1:0]      hip_angle,
  output logic signed [ANG_W-1:0]      knee_angle,
  output logic [1:0]                   status
);

  logic [LEN_W-1:0]        l1, l2;
  logic signed [ANG_W-1:0] hmin, hmax, kmin, kmax;
  logic signed [ANG_W-1:0] last_h, last_k;

  logic signed [POS_W-1:0] x_r, z_r;
  logic [1:0]              mode_r;
  logic signed [47:0]      dsq, t1, t2, num;
  logic [43:0]             den, rdiv;
  logic [30:0]             q;
  logic signed [31:0]      c;
  logic [61:0]             sqv, res, one;
  logic signed [AT_W-1:0]  py, px, ax, ay;
  logic signed [Z_W-1:0]   az;
  logic                    ysign, zero_r;
  logic signed [RAW_W-1:0] phi, qkraw, psi;
  logic signed [ANG_W-1:0] qh, qk, best_h, best_k;
  logic [COST_W-1:0]       lead_cost;
  logic                    found;
  logic [CNT_W-1:0]        cnt;

  // shared multiplier
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic [LEN_W:0]     lsum;
  logic [LEN_W-1:0]   ldiff;
  logic signed [31:0] s_w, s2;
  logic               neg;

  assign lsum  = {1'b0, l1} + {1'b0, l2};
  assign ldiff = (l1 >= l2) ? (l1 - l2) : (l2 - l1);
  assign s_w   = signed'({1'b0, res[30:0]});
  assign neg   = (mode_r == 2'd0) || (mode_r[1] && cmd.cand);
  assign s2    = neg ? -s_w : s_w;

  always_comb begin
    mul_a = 32'sd0;
    mul_b = 32'sd0;
    case (cmd.op)
      OP_DSQ1: begin mul_a = 32'(x_r); mul_b = 32'(x_r); end
      OP_DSQ2: begin mul_a = 32'(z_r); mul_b = 32'(z_r); end
      OP_LSUM: begin mul_a = signed'({11'b0, lsum}); mul_b = signed'({11'b0, lsum}); end
      OP_LDIF: begin mul_a = signed'({12'b0, ldiff}); mul_b = signed'({12'b0, ldiff}); end
      OP_L1SQ: begin mul_a = signed'({12'b0, l1}); mul_b = signed'({12'b0, l1}); end
      OP_L2SQ: begin mul_a = signed'({12'b0, l2}); mul_b = signed'({12'b0, l2}); end
      OP_DEN:  begin mul_a = signed'({12'b0, l1}); mul_b = signed'({12'b0, l2}); end
      OP_CSQ:  begin mul_a = c; mul_b = c; end
      OP_PSI_Y: begin mul_a = signed'({12'b0, l2}); mul_b = s2; end
      OP_PSI_X: begin mul_a = signed'({12'b0, l2}); mul_b = c; end
      default: begin mul_a = 32'sd0; mul_b = 32'sd0; end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // divider step
  logic [43:0] rs;
  logic        div_ge;
  assign rs     = (cnt == '0) ? rdiv : {rdiv[42:0], 1'b0};
  assign div_ge = rs >= den;

  // square root step
  logic [61:0] trial;
  logic        sq_ge;
  assign trial = res + one;
  assign sq_ge = sqv >= trial;

  // CORDIC
  logic signed [AT_W-1:0] ax_abs, ay_abs, m_abs, ys, xs, ld_x, ld_y, ax_half, ay_half;
  logic                   ld_neg;
  logic                   m_big, m_small;
  assign ax_abs  = (ax < 0) ? -ax : ax;
  assign ay_abs  = (ay < 0) ? -ay : ay;
  assign m_abs   = (ax_abs > ay_abs) ? ax_abs : ay_abs;
  assign m_big   = m_abs >= (AT_W'(1) <<< 51);
  assign m_small = m_abs < (AT_W'(1) <<< 50);
  assign ys      = ay >>> cnt;
  assign xs      = ax >>> cnt;
  // halving truncates toward zero
  assign ax_half = (ax + signed'({{(AT_W-1){1'b0}}, ax[AT_W-1]})) >>> 1;
  assign ay_half = (ay + signed'({{(AT_W-1){1'b0}}, ay[AT_W-1]})) >>> 1;

  always_comb begin
    case (cmd.job)
      JOB_PHI: begin
        ld_y = AT_W'(z_r); ld_x = AT_W'(x_r); ld_neg = 1'b0;
      end
      JOB_KNEE: begin
        ld_y = AT_W'(s2); ld_x = AT_W'(c); ld_neg = neg;
      end
      default: begin
        ld_y = py; ld_x = px; ld_neg = neg;
      end
    endcase
  end

  logic signed [RAW_W-1:0] ang_out, qh_w, qk_w, dh, dk;
  logic [RAW_W-1:0]        ah, ak;
  logic [COST_W-1:0]       cost;
  logic                    inlim;
  logic [31:0]             qc;

  assign ang_out = zero_r ? '0 : round_ang(az);
  assign qh_w    = wrap_ang(phi - psi);
  assign qk_w    = wrap_ang(qkraw);
  assign dh      = wrap_ang(RAW_W'(qh) - RAW_W'(last_h));
  assign dk      = wrap_ang(RAW_W'(qk) - RAW_W'(last_k));
  assign ah      = (dh < 0) ? RAW_W'(-dh) : RAW_W'(dh);
  assign ak      = (dk < 0) ? RAW_W'(-dk) : RAW_W'(dk);
  assign cost    = COST_W'(ah) * COST_W'(10) + COST_W'(ak) * COST_W'(3);
  assign inlim   = (qh >= hmin) && (qh <= hmax) && (qk >= kmin) && (qk <= kmax);
  assign qc      = (q > 31'(1 << 30)) ? 32'(1 << 30) : {1'b0, q};

  always_comb begin
    stat.link_zero = (l1 == '0) || (l2 == '0);
    stat.unreach   = (dsq > t1) || (dsq < t2);
    stat.div_last  = (cnt == CNT_W'(30));
    stat.sqrt_last = (cnt == CNT_W'(30));
    stat.at_zero   = zero_r;
    stat.at_normed = !m_big && !m_small;
    stat.rot_last  = (cnt == CNT_W'(CORDIC_N - 1));
    stat.both      = mode_r[1];
  end

  // configuration and state that reset defines
  always_ff @(posedge clk) begin
    if (rst) begin
      l1     <= '0;
      l2     <= '0;
      hmin   <= -19'sd82355;
      hmax   <= 19'sd205887;
      kmin   <= -19'sd185299;
      kmax   <= 19'sd185299;
      last_h <= '0;
      last_k <= '0;
      found  <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          REG_UPPER_LEN: l1   <= cfg_data;
          REG_LOWER_LEN: l2   <= cfg_data;
          REG_HIP_MIN:   hmin <= signed'(cfg_data[ANG_W-1:0]);
          REG_HIP_MAX:   hmax <= signed'(cfg_data[ANG_W-1:0]);
          REG_KNEE_MIN:  kmin <= signed'(cfg_data[ANG_W-1:0]);
          REG_KNEE_MAX:  kmax <= signed'(cfg_data[ANG_W-1:0]);
          default: ;
        endcase
      end
      case (cmd.op)
        OP_LATCH: found <= 1'b0;
        OP_COST: begin
          if (inlim && (!found || cost < lead_cost)) found <= 1'b1;
        end
        OP_FINISH: begin
          if (cmd.code == ST_OK && found) begin
            last_h <= best_h;
            last_k <= best_k;
          end
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LATCH: begin
        x_r    <= foot_x;
        z_r    <= foot_z;
        mode_r <= branch_mode;
      end
      OP_DSQ1: dsq <= mul_p[47:0];
      OP_DSQ2: dsq <= dsq + mul_p[47:0];
      OP_LSUM: t1  <= mul_p[47:0];
      OP_LDIF: t2  <= mul_p[47:0];
      OP_L1SQ: num <= dsq - mul_p[47:0];
      OP_L2SQ: num <= num - mul_p[47:0];
      OP_DEN: begin
        den  <= {mul_p[42:0], 1'b0};
        rdiv <= (num < 0) ? 44'(-num) : 44'(num);
        q    <= '0;
        cnt  <= '0;
      end
      OP_DIV: begin
        rdiv <= div_ge ? (rs - den) : rs;
        q    <= {q[29:0], div_ge};
        cnt  <= cnt + 1'b1;
      end
      OP_CSET: c <= (num < 0) ? -signed'(qc) : signed'(qc);
      OP_CSQ: begin
        sqv <= (62'(1) << 60) - mul_p[61:0];
        one <= 62'(1) << 60;
        res <= '0;
        cnt <= '0;
      end
      OP_SQRT: begin
        if (sq_ge) begin
          sqv <= sqv - trial;
          res <= (res >> 1) + one;
        end else begin
          res <= res >> 1;
        end
        one <= one >> 2;
        cnt <= cnt + 1'b1;
      end
      OP_PSI_Y: py <= mul_p[AT_W-1:0];
      OP_PSI_X: px <= signed'({{(AT_W-LEN_W-30){1'b0}}, l1, 30'b0}) + mul_p[AT_W-1:0];
      OP_AT_LOAD: begin
        ax     <= ld_x;
        ay     <= ld_y;
        ysign  <= (ld_y < 0) || ((ld_y == 0) && ld_neg);
        zero_r <= (ld_x == 0) && (ld_y == 0);
      end
      OP_AT_NORM: begin
        if (m_big) begin
          ax <= ax_half;
          ay <= ay_half;
        end else if (m_small) begin
          ax <= ax <<< 1;
          ay <= ay <<< 1;
        end
      end
      OP_AT_FIX: begin
        // left half plane: start from +-pi and mirror the vector
        if (ax < 0) begin
          az <= ysign ? -PI_Q30 : PI_Q30;
          ax <= -ax;
          ay <= -ay;
        end else begin
          az <= '0;
        end
        cnt <= '0;
      end
      OP_AT_ROT: begin
        if (ay > 0) begin
          ax <= ax + ys;
          ay <= ay - xs;
          az <= az + ATAN_TAB[cnt];
        end else begin
          ax <= ax - ys;
          ay <= ay + xs;
          az <= az - ATAN_TAB[cnt];
        end
        cnt <= cnt + 1'b1;
      end
      OP_AT_STORE: begin
        case (cmd.job)
          JOB_PHI:  phi   <= ang_out;
          JOB_KNEE: qkraw <= ang_out;
          default:  psi   <= ang_out;
        endcase
      end
      OP_WRAP: begin
        qh <= qh_w[ANG_W-1:0];
        qk <= qk_w[ANG_W-1:0];
      end
      OP_COST: begin
        if (inlim && (!found || cost < lead_cost)) begin
          lead_cost <= cost;
          best_h    <= qh;
          best_k    <= qk;
        end
      end
      OP_FINISH: begin
        if (cmd.code == ST_OK && found) begin
          status     <= ST_OK;
          hip_angle  <= best_h;
          knee_angle <= best_k;
        end else begin
          status     <= (cmd.code == ST_OK) ? ST_NO_SOL : cmd.code;
          hip_angle  <= '0;
          knee_angle <= '0;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: src/two_link_inverse_kinematics_top.sv
// Sequence: an unset link or an unreachable target ends the job early; otherwise the
// job runs the 31-step divider, the 31-step square root and three or five passes of
// the shared CORDIC unit (operand normalisation shifts one bit at a time, then 18
// rotation steps).
// Throughput: one item at a time; the next item is taken while a result waits.
// Reset: synchronous, clears the sequencer, output valid and last angles, and loads
// the register defaults (link lengths zero).
`default_nettype none
module two_link_inverse_kinematics_top
  import tlik_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_write,
  input  wire logic [IDX_W-1:0]        cfg_index,
  input  wire logic [CFG_W-1:0]        cfg_data,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic signed [POS_W-1:0] foot_x,
  input  wire logic signed [POS_W-1:0] foot_z,
  input  wire logic [1:0]              branch_mode,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [ANG_W-1:0]      hip_angle,
  output logic signed [ANG_W-1:0]      knee_angle,
  output logic [1:0]                   status
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tlik_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  tlik_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .foot_x      (foot_x),
    .foot_z      (foot_z),
    .branch_mode (branch_mode),
    .cmd         (cmd),
    .stat        (stat),
    .hip_angle   (hip_angle),
    .knee_angle  (knee_angle),
    .status      (status)
  );

endmodule
`default_nettype wire

// File: tb/tb_two_link_inverse_kinematics_top.sv
// Self-checking testbench for the two-link inverse kinematics block.
`default_nettype none
module tb_two_link_inverse_kinematics_top
  import tlik_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [ANG_W-1:0] hip;
    logic signed [ANG_W-1:0] knee;
    ik_status_t              st;
  } ik_result_t;

  localparam longint PI_Q = 64'sd3373259426;
  localparam longint ATAN_Q30 [0:27] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [POS_W-1:0] foot_x = '0;
  logic signed [POS_W-1:0] foot_z = '0;
  logic [1:0] branch_mode = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [ANG_W-1:0] hip_angle;
  logic signed [ANG_W-1:0] knee_angle;
  logic [1:0] status;

  two_link_inverse_kinematics_top i_dut (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .foot_x, .foot_z, .branch_mode,
    .out_valid, .out_stall, .hip_angle, .knee_angle, .status
  );

  always #5 clk = ~clk;

  // predictor copy of registers and joint memory
  longint len_upper, len_lower, hip_lo, hip_hi, knee_lo, knee_hi;
  longint prev_hip, prev_knee;

  ik_result_t pending_angles[$];
  int mismatches = 0;
  int solved = 0;
  int status_seen [4] = '{0, 0, 0, 0};
  int gap_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint round_to_ang(longint v);
    longint half;
    half = 64'sd1 <<< (ANGLE_SHIFT - 1);
    if (v >= 0) return (v + half) >>> ANGLE_SHIFT;
    return -((-v + half) >>> ANGLE_SHIFT);
  endfunction

  function automatic longint wrap_pi(longint a);
    longint p, r;
    p = round_to_ang(PI_Q);
    r = a % (2 * p);
    if (r > p) r -= 2 * p;
    if (r < -p) r += 2 * p;
    return r;
  endfunction

  function automatic longint vector_angle(longint y, longint x, bit yneg);
    bit ysign;
    longint m, z, ys, xs;
    ysign = (y < 0) || (y == 0 && yneg);
    z = 0;
    if (x == 0 && y == 0) return 0;
    m = mag(x) > mag(y) ? mag(x) : mag(y);
    while (m >= (64'sd1 <<< 51)) begin
      x /= 2; y /= 2; m /= 2;
    end
    while (m < (64'sd1 <<< 50)) begin
      x *= 2; y *= 2; m *= 2;
    end
    if (x < 0) begin
      z = ysign ? -PI_Q : PI_Q;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_N; i++) begin
      ys = y >>> i;
      xs = x >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += ATAN_Q30[i];
      end else begin
        x -= ys; y += xs; z -= ATAN_Q30[i];
      end
    end
    return z;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, one;
    res = 0;
    one = 64'd1 << 62;
    while (one > v) one >>= 2;
    while (one != 0) begin
      if (v >= res + one) begin
        v -= res + one;
        res = (res >> 1) + one;
      end else begin
        res >>= 1;
      end
      one >>= 2;
    end
    return res;
  endfunction

  // solves one foot target and advances the joint memory on success
  function automatic ik_result_t solve_leg(longint x, longint z, int mode);
    ik_result_t res;
    longint dsq, lsum, ldiff, num, c, s, phi, s2, qk, psi, qh, cost;
    longint best_h, best_k, lead_cost;
    longint unsigned r, q, d;
    bit found, neg;
    res.hip = '0;
    res.knee = '0;
    best_h = 0; best_k = 0; lead_cost = 0; found = 0;
    if (len_upper == 0 || len_lower == 0) begin
      res.st = ST_NO_LINK;
      return res;
    end
    dsq = x * x + z * z;
    lsum = len_upper + len_lower;
    ldiff = mag(len_upper - len_lower);
    if (dsq > lsum * lsum || dsq < ldiff * ldiff) begin
      res.st = ST_UNREACH;
      return res;
    end
    num = dsq - len_upper * len_upper - len_lower * len_lower;
    d = 2 * len_upper * len_lower;
    r = mag(num);
    q = 0;
    if (r >= d) begin
      q = 1; r -= d;
    end
    for (int i = 0; i < 30; i++) begin
      r <<= 1; q <<= 1;
      if (r >= d) begin
        r -= d; q |= 1;
      end
    end
    if (q > (64'd1 << 30)) q = 64'd1 << 30;
    c = num < 0 ? -longint'(q) : longint'(q);
    s = longint'(root_floor((64'd1 << 60) - longint'(c * c)));
    phi = round_to_ang(vector_angle(z, x, 1'b0));
    for (int k = 0; k < 2; k++) begin
      neg = (mode == 0) || (mode >= 2 && k == 1);
      s2 = neg ? -s : s;
      qk = wrap_pi(round_to_ang(vector_angle(s2, c, neg)));
      psi = round_to_ang(vector_angle(len_lower * s2,
                                      len_upper * (64'sd1 <<< 30) + len_lower * c, neg));
      qh = wrap_pi(phi - psi);
      if (qh < hip_lo || qh > hip_hi || qk < knee_lo || qk > knee_hi) continue;
      cost = 10 * mag(wrap_pi(qh - prev_hip)) + 3 * mag(wrap_pi(qk - prev_knee));
      if (!found || cost < lead_cost) begin
        found = 1; lead_cost = cost; best_h = qh; best_k = qk;
      end
    end
    if (!found) begin
      res.st = ST_NO_SOL;
    end else begin
      res.st = ST_OK;
      prev_hip = best_h;
      prev_knee = best_k;
      res.hip = best_h[ANG_W-1:0];
      res.knee = best_k[ANG_W-1:0];
    end
    return res;
  endfunction

  // input side: predict on every accepted item
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      pending_angles.push_back(solve_leg(foot_x, foot_z, branch_mode));
    end
  end

  // output side: compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    ik_result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (pending_angles.size() == 0) begin
        $error("result with no item outstanding: hip %0d knee %0d status %0d",
               hip_angle, knee_angle, status);
        mismatches++;
      end else begin
        exp_r = pending_angles.pop_front();
        solved++;
        status_seen[exp_r.st]++;
        if (hip_angle !== exp_r.hip) begin
          $error("hip_angle expected %0d got %0d", exp_r.hip, hip_angle);
          mismatches++;
        end
        if (knee_angle !== exp_r.knee) begin
          $error("knee_angle expected %0d got %0d", exp_r.knee, knee_angle);
          mismatches++;
        end
        if (status !== exp_r.st) begin
          $error("status expected %0d got %0d", exp_r.st, status);
          mismatches++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall = 1'b1;
      hold_cycles--;
    end else begin
      out_stall = ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_target(longint x, longint z, int mode);
    while ($urandom_range(99) < gap_pct) @(negedge clk);
    foot_x = x[POS_W-1:0];
    foot_z = z[POS_W-1:0];
    branch_mode = mode[1:0];
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain;
    while (pending_angles.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, longint value);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = value[CFG_W-1:0];
    case (idx)
      REG_UPPER_LEN: len_upper = value & 64'hFFFFF;
      REG_LOWER_LEN: len_lower = value & 64'hFFFFF;
      REG_HIP_MIN:   hip_lo = longint'($signed(value[ANG_W-1:0]));
      REG_HIP_MAX:   hip_hi = longint'($signed(value[ANG_W-1:0]));
      REG_KNEE_MIN:  knee_lo = longint'($signed(value[ANG_W-1:0]));
      default:       knee_hi = longint'($signed(value[ANG_W-1:0]));
    endcase
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic set_limits(longint hmin, longint hmax, longint kmin, longint kmax);
    write_reg(REG_HIP_MIN, hmin);
    write_reg(REG_HIP_MAX, hmax);
    write_reg(REG_KNEE_MIN, kmin);
    write_reg(REG_KNEE_MAX, kmax);
  endtask

  task automatic set_links(longint l1, longint l2);
    write_reg(REG_UPPER_LEN, l1);
    write_reg(REG_LOWER_LEN, l2);
  endtask

  task automatic test_links_unset;
    send_target(100000, 0, 2);
    send_target(-2000000, 2000000, 0);
    drain();
    set_links(300000, 0);
    send_target(200000, 100000, 1);
    drain();
  endtask

  task automatic test_directed_targets;
    set_links(300000, 250000);
    set_limits(-205887, 205887, -205887, 205887);
    send_target(0, 0, 2);               // inside inner reach
    send_target(2000000, -2000000, 1);  // far outside
    send_target(-2000000, 2000000, 0);
    send_target(550000, 0, 2);          // full stretch
    send_target(-550000, 0, 0);         // full stretch behind, knee sine zero
    send_target(-550000, 0, 1);
    send_target(50000, 0, 2);           // fully folded
    send_target(0, -400000, 0);
    send_target(0, -400000, 1);
    send_target(0, -400000, 2);
    send_target(0, -400000, 3);
    send_target(-300000, -200000, 2);
    send_target(-300000, 0, 2);
    drain();
    set_links(1000000, 1000000);
    send_target(0, 0, 2);               // equal links, target at the hip
    send_target(1999999, 0, 2);
    send_target(-1414213, -1414213, 3);
    send_target(0, 2000000, 0);
    drain();
    set_links(1, 1000000);
    send_target(999999, 0, 2);
    send_target(0, -1000000, 2);
    drain();
    set_links(300000, 250000);
    set_limits(100000, -100000, -185299, 185299);  // crossed hip limits
    send_target(0, -400000, 2);
    drain();
    set_limits(-82355, 205887, 100, -100);         // crossed knee limits
    send_target(0, -400000, 2);
    drain();
  endtask

  task automatic random_setup;
    longint l1, l2, a, b;
    case ($urandom_range(9))
      0: begin l1 = 1000000; l2 = 1000000; end
      1: begin l1 = 1; l2 = $urandom_range(1, 1000000); end
      2: begin l1 = $urandom_range(1, 1000000); l2 = l1; end
      default: begin l1 = $urandom_range(1, 1000000); l2 = $urandom_range(1, 1000000); end
    endcase
    set_links(l1, l2);
    case ($urandom_range(5))
      0: set_limits(-82355, 205887, -185299, 185299);
      1: set_limits(-205887, 205887, -205887, 205887);
      2: begin
        a = $urandom_range(0, 2 * 205887) - 205887;
        b = $urandom_range(0, 2 * 205887) - 205887;
        set_limits(a, b, -205887, 205887);
      end
      default: set_limits(-longint'($urandom_range(205887)), $urandom_range(205887),
                          -longint'($urandom_range(205887)), $urandom_range(205887));
    endcase
  endtask

  task automatic random_targets(int count);
    longint span, x, z;
    span = len_upper + len_lower;
    if (span > 2000000) span = 2000000;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0) begin
        x = longint'($urandom_range(4000000)) - 2000000;
        z = longint'($urandom_range(4000000)) - 2000000;
        if ($urandom_range(1)) x = $signed(POS_W'($urandom));
      end else begin
        x = longint'($urandom_range(2 * span)) - span;
        z = longint'($urandom_range(2 * span)) - span;
      end
      send_target(x, z, $urandom_range(3));
    end
  endtask

  task automatic test_random_phase(int gap, int stall);
    gap_pct = gap;
    stall_pct = stall;
    for (int set = 0; set < 4; set++) begin
      random_setup();
      random_targets(100);
      drain();
    end
  endtask

  task automatic test_output_hold;
    gap_pct = 0;
    stall_pct = 0;
    set_links(400000, 350000);
    hold_cycles = 800;
    random_targets(12);
    drain();
  endtask

  initial begin
    len_upper = 0; len_lower = 0;
    hip_lo = -82355; hip_hi = 205887; knee_lo = -185299; knee_hi = 185299;
    prev_hip = 0; prev_knee = 0;
    repeat (5) @(negedge clk);
    rst = 1'b0;
    test_links_unset();
    test_directed_targets();
    test_random_phase(0, 0);
    test_random_phase(67, 0);
    test_random_phase(0, 67);
    test_random_phase(23, 23);
    test_output_hold();
    repeat (450) @(negedge clk);
    $display("checked %0d results: ok %0d, no link %0d, unreachable %0d, no solution %0d",
             solved, status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    $display("link settings from 1 um to 1 m, crossed and full limits, four idling phases");
    if (mismatches == 0 && pending_angles.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("timeout with %0d results outstanding", pending_angles.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
`default_nettype wire

// File: sim.f
src/tlik_pkg.sv
src/tlik_ctrl.sv
src/tlik_datapath.sv
src/two_link_inverse_kinematics_top.sv
tb/tb_two_link_inverse_kinematics_top.sv
